>>> rtl/trce_pkg.sv
// Shared types and constants of the transport receiver connection engine.
package trce_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OFFSET_W   = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SOCKET_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_ZERO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_ONE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_TWO      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_THREE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSEWAIT     = 3'd5;

  localparam logic RES_REPLY  = 1'b0;
  localparam logic RES_STATUS = 1'b1;

  typedef enum logic [1:0] {
    REQ_SEGMENT,
    REQ_ACCEPT,
    REQ_CONSUME,
    REQ_TICK
  } req_type_t;

  typedef enum logic [2:0] {
    SEG_SYN,
    SEG_SYNACK,
    SEG_FIN,
    SEG_FINACK,
    SEG_DATA,
    SEG_DATAACK
  } seg_kind_t;

  typedef enum logic [1:0] {
    CONN_CLOSED,
    CONN_LISTEN,
    CONN_EST,
    CONN_CWAIT
  } conn_state_t;

  typedef enum logic [1:0] {
    STS_OK,
    STS_WRONG_STATE,
    STS_NO_DATA,
    STS_NO_SOCKET
  } status_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } trce_cmd_t;

  typedef struct packed {
    logic has_result;
  } trce_stat_t;

endpackage

>>> rtl/trce_ifs.sv
// Request and result channel interfaces.
interface trce_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  seg_kind;
  logic [15:0] source_port;
  logic [15:0] target_port;
  logic [31:0] seq_number;
  logic [15:0] payload_length;
  logic [1:0]  sock_index;
  logic [12:0] consume_length;

  modport source (
    output valid, req_type, seg_kind, source_port, target_port, seq_number,
           payload_length, sock_index, consume_length,
    input  ready
  );
  modport sink (
    input  valid, req_type, seg_kind, source_port, target_port, seq_number,
           payload_length, sock_index, consume_length,
    output ready
  );
endinterface

interface trce_res_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [2:0]  reply_kind;
  logic [15:0] reply_src_port;
  logic [15:0] reply_dst_port;
  logic [31:0] ack_number;
  logic        payload_stored;
  logic [12:0] store_offset;
  logic [1:0]  status;

  modport source (
    output valid, result_kind, reply_kind, reply_src_port, reply_dst_port,
           ack_number, payload_stored, store_offset, status,
    input  ready
  );
  modport sink (
    input  valid, result_kind, reply_kind, reply_src_port, reply_dst_port,
           ack_number, payload_stored, store_offset, status,
    output ready
  );
endinterface

>>> rtl/trce_ctrl.sv
// Request sequencer and result-valid control.
module trce_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output trce_pkg::trce_cmd_t   cmd,
  input  trce_pkg::trce_stat_t  stat
);
  import trce_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      CTL_IDLE: if (cmd.capture) state_next = CTL_EXEC;
      CTL_EXEC: state_next = CTL_IDLE;
      default:  state_next = CTL_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      CTL_IDLE: begin
        // result register must be empty by the time the request executes
        in_ready    = !out_valid || out_ready;
        cmd.capture = in_valid && in_ready;
      end
      CTL_EXEC: cmd.execute = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CTL_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.execute && stat.has_result) out_valid <= 1'b1;
      else if (out_ready)                 out_valid <= 1'b0;
    end
  end

  a_exec_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.execute)
    else $error("execute did not follow capture");

  a_exec_has_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> $past(cmd.capture))
    else $error("execute without a captured request");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> !out_valid)
    else $error("result register still full at execute");

  a_result_only_on_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.execute))
    else $error("result raised outside execute");

endmodule

>>> rtl/trce_datapath.sv
// Connection table, configuration registers, request decode and result register.
module trce_datapath #(
  parameter int NUM_SOCKETS    = 4,
  parameter int RECV_BUF_BYTES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [trce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trce_pkg::CFG_DATA_W-1:0] cfg_data,
  input  trce_pkg::trce_cmd_t             cmd,
  output trce_pkg::trce_stat_t            stat,
  input  logic [1:0]                      req_type,
  input  logic [2:0]                      seg_kind,
  input  logic [15:0]                     source_port,
  input  logic [15:0]                     target_port,
  input  logic [31:0]                     seq_number,
  input  logic [15:0]                     payload_length,
  input  logic [1:0]                      sock_index,
  input  logic [12:0]                     consume_length,
  output logic                            result_kind,
  output logic [2:0]                      reply_kind,
  output logic [15:0]                     reply_src_port,
  output logic [15:0]                     reply_dst_port,
  output logic [31:0]                     ack_number,
  output logic                            payload_stored,
  output logic [12:0]                     store_offset,
  output logic [1:0]                      status
);
  import trce_pkg::*;

  localparam int IDX_W = (NUM_SOCKETS > 1) ? $clog2(NUM_SOCKETS) : 1;
  localparam int BUF_W = $clog2(RECV_BUF_BYTES);
  localparam int SUM_W = ((BUF_W > 16) ? BUF_W : 16) + 1;
  localparam logic [SUM_W-1:0] BUF_LIMIT = SUM_W'(RECV_BUF_BYTES);

  // configuration
  logic [3:0]  socket_enable;
  logic [15:0] srv_port [4];
  logic [15:0] closewait_ticks;

  // captured request
  logic [1:0]  rq_type;
  logic [2:0]  rq_kind;
  logic [15:0] rq_sport;
  logic [15:0] rq_tport;
  logic [31:0] rq_seq;
  logic [15:0] rq_plen;
  logic [1:0]  rq_sidx;
  logic [12:0] rq_clen;

  // connection table
  conn_state_t       conn_state           [NUM_SOCKETS];
  logic [15:0]       peer_port            [NUM_SOCKETS];
  logic [31:0]       expected_seq         [NUM_SOCKETS];
  logic [BUF_W-1:0]  buffered_bytes       [NUM_SOCKETS];
  logic [15:0]       closewait_count      [NUM_SOCKETS];
  conn_state_t       conn_state_next      [NUM_SOCKETS];
  logic [15:0]       peer_port_next       [NUM_SOCKETS];
  logic [31:0]       expected_seq_next    [NUM_SOCKETS];
  logic [BUF_W-1:0]  buffered_bytes_next  [NUM_SOCKETS];
  logic [15:0]       closewait_count_next [NUM_SOCKETS];

  // result register next values
  logic        result_kind_next;
  logic [2:0]  reply_kind_next;
  logic [15:0] reply_src_port_next;
  logic [15:0] reply_dst_port_next;
  logic [31:0] ack_number_next;
  logic        payload_stored_next;
  logic [12:0] store_offset_next;
  logic [1:0]  status_next;

  logic             hit;
  logic [IDX_W-1:0] hidx;
  logic [IDX_W-1:0] sel;
  logic             sidx_ok;
  conn_state_t      sel_state;
  logic [31:0]      sel_seq;
  logic [BUF_W-1:0] sel_buf;
  logic [SUM_W-1:0] sum_bytes;
  logic             in_order;
  logic [31:0]      seq_adv;

  // port match, last enabled entry wins
  always_comb begin
    hit  = 1'b0;
    hidx = '0;
    for (int i = 0; i < NUM_SOCKETS; i++) begin
      if (socket_enable[i] && srv_port[i] == rq_tport) begin
        hit  = 1'b1;
        hidx = IDX_W'(i);
      end
    end
  end

  assign sidx_ok   = (int'(rq_sidx) < NUM_SOCKETS) && socket_enable[rq_sidx];
  assign sel       = (rq_type == REQ_SEGMENT) ? hidx : rq_sidx[IDX_W-1:0];
  assign sel_state = conn_state[sel];
  assign sel_seq   = expected_seq[sel];
  assign sel_buf   = buffered_bytes[sel];
  assign sum_bytes = SUM_W'(sel_buf) + SUM_W'(rq_plen);
  assign in_order  = (rq_seq == sel_seq) && (sum_bytes < BUF_LIMIT);
  assign seq_adv   = rq_seq + 32'(rq_plen);

  always_comb begin
    conn_state_next      = conn_state;
    peer_port_next       = peer_port;
    expected_seq_next    = expected_seq;
    buffered_bytes_next  = buffered_bytes;
    closewait_count_next = closewait_count;
    stat.has_result      = 1'b0;
    result_kind_next     = RES_REPLY;
    reply_kind_next      = '0;
    reply_src_port_next  = '0;
    reply_dst_port_next  = '0;
    ack_number_next      = '0;
    payload_stored_next  = 1'b0;
    store_offset_next    = '0;
    status_next          = '0;

    if (cmd.execute) begin
      case (rq_type)
        REQ_SEGMENT: begin
          if (hit) begin
            reply_src_port_next = srv_port[sel];
            reply_dst_port_next = peer_port[sel];
            case (sel_state)
              CONN_LISTEN: begin
                if (rq_kind == SEG_SYN) begin
                  stat.has_result         = 1'b1;
                  reply_kind_next         = SEG_SYNACK;
                  reply_dst_port_next     = rq_sport;
                  peer_port_next[sel]     = rq_sport;
                  conn_state_next[sel]    = CONN_EST;
                  expected_seq_next[sel]  = rq_seq;
                end
              end
              CONN_EST: begin
                if (rq_kind == SEG_SYN) begin
                  stat.has_result        = 1'b1;
                  reply_kind_next        = SEG_SYNACK;
                  expected_seq_next[sel] = rq_seq;
                end else if (rq_kind == SEG_DATA) begin
                  stat.has_result = 1'b1;
                  reply_kind_next = SEG_DATAACK;
                  ack_number_next = sel_seq;
                  if (in_order) begin
                    payload_stored_next      = 1'b1;
                    store_offset_next        = OFFSET_W'(SUM_W'(sel_buf));
                    buffered_bytes_next[sel] = sum_bytes[BUF_W-1:0];
                    expected_seq_next[sel]   = seq_adv;
                    ack_number_next          = seq_adv;
                  end
                end else if (rq_kind == SEG_FIN) begin
                  stat.has_result           = 1'b1;
                  reply_kind_next           = SEG_FINACK;
                  conn_state_next[sel]      = CONN_CWAIT;
                  closewait_count_next[sel] = closewait_ticks;
                end
              end
              CONN_CWAIT: begin
                if (rq_kind == SEG_FIN) begin
                  stat.has_result = 1'b1;
                  reply_kind_next = SEG_FINACK;
                end
              end
              default: ;
            endcase
          end
        end
        REQ_ACCEPT: begin
          stat.has_result  = 1'b1;
          result_kind_next = RES_STATUS;
          if (!sidx_ok) begin
            status_next = STS_NO_SOCKET;
          end else if (sel_state != CONN_CLOSED) begin
            status_next = STS_WRONG_STATE;
          end else begin
            status_next          = STS_OK;
            conn_state_next[sel] = CONN_LISTEN;
          end
        end
        REQ_CONSUME: begin
          stat.has_result  = 1'b1;
          result_kind_next = RES_STATUS;
          if (!sidx_ok) begin
            status_next = STS_NO_SOCKET;
          end else if (sel_state != CONN_EST) begin
            status_next = STS_WRONG_STATE;
          end else if (SUM_W'(sel_buf) < SUM_W'(rq_clen)) begin
            status_next = STS_NO_DATA;
          end else begin
            status_next              = STS_OK;
            buffered_bytes_next[sel] = BUF_W'(SUM_W'(sel_buf) - SUM_W'(rq_clen));
          end
        end
        REQ_TICK: begin
          for (int i = 0; i < NUM_SOCKETS; i++) begin
            if (conn_state[i] == CONN_CWAIT) begin
              if (closewait_count[i] <= 16'd1) begin
                closewait_count_next[i] = '0;
                conn_state_next[i]      = CONN_CLOSED;
              end else begin
                closewait_count_next[i] = closewait_count[i] - 16'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end

    // a newly enabled entry starts out as after reset
    if (cfg_we && cfg_index == CFG_SOCKET_ENABLE) begin
      for (int i = 0; i < NUM_SOCKETS; i++) begin
        if (cfg_data[i] && !socket_enable[i]) begin
          conn_state_next[i]      = CONN_CLOSED;
          peer_port_next[i]       = '0;
          expected_seq_next[i]    = '0;
          buffered_bytes_next[i]  = '0;
          closewait_count_next[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      socket_enable   <= '0;
      closewait_ticks <= 16'd1;
      for (int i = 0; i < 4; i++) srv_port[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOCKET_ENABLE: socket_enable   <= cfg_data[3:0];
        CFG_PORT_ZERO:     srv_port[0]     <= cfg_data;
        CFG_PORT_ONE:      srv_port[1]     <= cfg_data;
        CFG_PORT_TWO:      srv_port[2]     <= cfg_data;
        CFG_PORT_THREE:    srv_port[3]     <= cfg_data;
        CFG_CLOSEWAIT:     closewait_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SOCKETS; i++) begin
        conn_state[i]      <= CONN_CLOSED;
        peer_port[i]       <= '0;
        expected_seq[i]    <= '0;
        buffered_bytes[i]  <= '0;
        closewait_count[i] <= '0;
      end
    end else begin
      conn_state      <= conn_state_next;
      peer_port       <= peer_port_next;
      expected_seq    <= expected_seq_next;
      buffered_bytes  <= buffered_bytes_next;
      closewait_count <= closewait_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rq_type  <= req_type;
      rq_kind  <= seg_kind;
      rq_sport <= source_port;
      rq_tport <= target_port;
      rq_seq   <= seq_number;
      rq_plen  <= payload_length;
      rq_sidx  <= sock_index;
      rq_clen  <= consume_length;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && stat.has_result) begin
      result_kind    <= result_kind_next;
      reply_kind     <= reply_kind_next;
      reply_src_port <= reply_src_port_next;
      reply_dst_port <= reply_dst_port_next;
      ack_number     <= ack_number_next;
      payload_stored <= payload_stored_next;
      store_offset   <= store_offset_next;
      status         <= status_next;
    end
  end

endmodule

>>> rtl/transport_receiver_connection_engine.sv
// Top level of the transport receiver connection engine.
// Server side of a go-back-N transport: each request (segment, accept, consume or
// tick) is taken on req and executed against a table of up to NUM_SOCKETS
// connection entries, matched by server port with the highest enabled match
// winning. Each request is captured and then executed (port match, table update
// and loading of the result register); a new request is taken once the previous
// one has executed and res drains. The result register sits between the two
// sides, so a request is accepted while the previous result is being taken.
// Segments that the entry state does not handle and ticks give no result.
// Configuration writes go in directly and are to be issued only while idle.
module transport_receiver_connection_engine #(
  parameter int NUM_SOCKETS    = 4,
  parameter int RECV_BUF_BYTES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [trce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trce_pkg::CFG_DATA_W-1:0] cfg_data,
  trce_req_if.sink                        req,
  trce_res_if.source                      res
);
  import trce_pkg::*;

  trce_cmd_t  cmd;
  trce_stat_t stat;

  trce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  trce_datapath #(
    .NUM_SOCKETS    (NUM_SOCKETS),
    .RECV_BUF_BYTES (RECV_BUF_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .req_type       (req.req_type),
    .seg_kind       (req.seg_kind),
    .source_port    (req.source_port),
    .target_port    (req.target_port),
    .seq_number     (req.seq_number),
    .payload_length (req.payload_length),
    .sock_index     (req.sock_index),
    .consume_length (req.consume_length),
    .result_kind    (res.result_kind),
    .reply_kind     (res.reply_kind),
    .reply_src_port (res.reply_src_port),
    .reply_dst_port (res.reply_dst_port),
    .ack_number     (res.ack_number),
    .payload_stored (res.payload_stored),
    .store_offset   (res.store_offset),
    .status         (res.status)
  );

endmodule
